// ===== hdl/pcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit packer package
// Shared constants, types and helper functions for the bit packer core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbp_pkg;

  // Size of the code table and the longest code it may hold.
  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned MAX_CODE_LEN = 32;

  // Stored codes never exceed the 32-bit pattern field.
  localparam int unsigned LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int unsigned LEN_W     = $clog2(LEN_LIMIT + 1);
  localparam int unsigned SYM_IDX_W = $clog2(SYMBOL_COUNT);

  // Accumulator: up to seven pending bits followed by one full code.
  localparam int unsigned ACC_W     = LEN_LIMIT + 7;
  localparam int unsigned TOT_W     = $clog2(ACC_W + 1);

  // Shared shifter, wide enough for the accumulator and the flush padding.
  localparam int unsigned SH_W      = (ACC_W > 15) ? ACC_W : 15;
  localparam int unsigned SH_AMT_W  = $clog2(SH_W);

  // Command codes.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // One code table entry.
  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [LEN_LIMIT-1:0] pat;
  } tbl_entry_t;

  // Write request into the code table.
  typedef struct packed {
    logic                 en;
    logic [SYM_IDX_W-1:0] addr;
    tbl_entry_t           entry;
  } tbl_wr_t;

  // Mask that keeps the low len bits of a code pattern.
  function automatic logic [LEN_LIMIT-1:0] pat_mask(logic [LEN_W-1:0] len);
    logic [LEN_LIMIT:0] m;
    m = {(LEN_LIMIT + 1){1'b1}} << len;
    return ~m[LEN_LIMIT-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pcbp_code_table.sv =====
// ----------------------------------------------------------------------------
// Prefix code table
// Single-port write, registered read storage for the code lengths and patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbp_code_table (
  input  wire logic                          clk_i,
  input  wire pcbp_pkg::tbl_wr_t             wr_i,
  input  wire logic                          rd_en_i,
  input  wire logic [pcbp_pkg::SYM_IDX_W-1:0] rd_addr_i,
  output pcbp_pkg::tbl_entry_t               rd_data_o
);

  pcbp_pkg::tbl_entry_t mem [pcbp_pkg::SYMBOL_COUNT];
  pcbp_pkg::tbl_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/pcbp_shifter.sv =====
// ----------------------------------------------------------------------------
// Shared right shifter
// Logical right shift used for merging codes, extracting bytes and padding.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbp_shifter (
  input  wire logic [pcbp_pkg::SH_W-1:0]     data_i,
  input  wire logic [pcbp_pkg::SH_AMT_W-1:0] amt_i,
  output logic      [pcbp_pkg::SH_W-1:0]     data_o
);

  assign data_o = data_i >> amt_i;

endmodule

`default_nettype wire

// ===== hdl/prefix_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit packer core
// Looks up prefix codes, packs them into bytes MSB first and flushes the tail.
// ----------------------------------------------------------------------------
// The block takes one command per input transfer. A load writes one table
// entry and completes in the cycle it is accepted, so loads may follow each
// other back to back. An encode completes n bytes, where n is 0 to 4: the
// table read is registered, a merge step places the code behind the pending
// bits, then each byte is brought down by the single shared right shifter.
// A flush sends a padded byte when bits are pending, then the trailer count.
// Output stalls hold back every step that sends a byte, since every byte
// the block sends, whether code, padding or trailer, passes through a single
// output register. While an encode or flush is in progress the input stall
// is held high; the next command is taken as soon as the last byte has been
// placed in the output register, even if that byte has not yet been taken.
// The last output marks the final byte caused by an input transfer. The code
// table has no reset; encoding a symbol whose entry was never loaded gives
// undefined bytes. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_bit_packer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [31:0] code_pattern_i,
  input  wire logic [5:0]  code_length_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  localparam int unsigned ACC_W     = pcbp_pkg::ACC_W;
  localparam int unsigned TOT_W     = pcbp_pkg::TOT_W;
  localparam int unsigned SH_W      = pcbp_pkg::SH_W;
  localparam int unsigned SH_AMT_W  = pcbp_pkg::SH_AMT_W;
  localparam int unsigned LEN_W     = pcbp_pkg::LEN_W;
  localparam int unsigned LEN_LIMIT = pcbp_pkg::LEN_LIMIT;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_MERGE      = 3'd1;
  localparam logic [2:0] ST_EMIT       = 3'd2;
  localparam logic [2:0] ST_FLUSH_DATA = 3'd3;
  localparam logic [2:0] ST_FLUSH_TRL  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [6:0]       pend_bits_q, pend_bits_d;
  logic [2:0]       pend_cnt_q, pend_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  logic in_xfer;
  logic slot_free;
  logic sym_in_range;

  pcbp_pkg::tbl_wr_t    tbl_wr;
  pcbp_pkg::tbl_entry_t tbl_rd;
  logic                 tbl_rd_en;
  logic [LEN_W-1:0]     load_len;

  logic [SH_W-1:0]     sh_in, sh_out;
  logic [SH_AMT_W-1:0] sh_amt;

  logic [TOT_W-1:0] merge_total;
  logic [TOT_W-1:0] emit_rem;

  // An input transfer completes when the sequencer is idle and valid is high.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // The output register can take a new byte when empty or being emptied.
  assign slot_free = !out_valid_q || !out_stall_i;

  assign sym_in_range = ({1'b0, symbol_i} < 9'(pcbp_pkg::SYMBOL_COUNT));

  // Loads saturate the length and drop pattern bits above it before storage.
  always_comb begin
    if (code_length_i > 6'(LEN_LIMIT)) begin
      load_len = LEN_W'(LEN_LIMIT);
    end else begin
      load_len = code_length_i[LEN_W-1:0];
    end
  end

  always_comb begin
    tbl_wr.en        = in_xfer && (cmd_i == pcbp_pkg::CMD_LOAD) && sym_in_range;
    tbl_wr.addr      = symbol_i[pcbp_pkg::SYM_IDX_W-1:0];
    tbl_wr.entry.len = load_len;
    tbl_wr.entry.pat = code_pattern_i[LEN_LIMIT-1:0] & pcbp_pkg::pat_mask(load_len);
  end

  assign tbl_rd_en = in_xfer && (cmd_i == pcbp_pkg::CMD_ENCODE) && sym_in_range;

  pcbp_code_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (symbol_i[pcbp_pkg::SYM_IDX_W-1:0]),
    .rd_data_o (tbl_rd)
  );

  // The one shifter serves the merge, emit and flush data steps: in the merge it moves the pending
  // bits up past the new code, in the emit steps it brings the next whole
  // byte down to the bottom, and in a flush it pads the tail with zeros.
  always_comb begin
    unique case (state_q)
      ST_MERGE: begin
        sh_in  = SH_W'({pend_bits_q, {LEN_LIMIT{1'b0}}});
        sh_amt = SH_AMT_W'(LEN_LIMIT) - SH_AMT_W'(tbl_rd.len);
      end
      ST_EMIT: begin
        sh_in  = SH_W'(acc_q);
        sh_amt = SH_AMT_W'(total_q - TOT_W'(8));
      end
      ST_FLUSH_DATA: begin
        sh_in  = SH_W'({pend_bits_q, 8'h00});
        sh_amt = SH_AMT_W'(pend_cnt_q);
      end
      default: begin
        sh_in  = '0;
        sh_amt = '0;
      end
    endcase
  end

  pcbp_shifter u_shifter (
    .data_i (sh_in),
    .amt_i  (sh_amt),
    .data_o (sh_out)
  );

  assign merge_total = TOT_W'(pend_cnt_q) + TOT_W'(tbl_rd.len);
  assign emit_rem    = total_q - TOT_W'(8);

  // Sequencer and data path.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    total_d     = total_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_i == pcbp_pkg::CMD_ENCODE && sym_in_range) begin
            state_d = ST_MERGE;
          end else if (cmd_i == pcbp_pkg::CMD_FLUSH) begin
            state_d = (pend_cnt_q != 3'd0) ? ST_FLUSH_DATA : ST_FLUSH_TRL;
          end
        end
      end

      ST_MERGE: begin
        acc_d   = sh_out[ACC_W-1:0] | ACC_W'(tbl_rd.pat);
        total_d = merge_total;
        if (merge_total < TOT_W'(8)) begin
          // No byte completes: the merged bits simply become the pending bits.
          pend_bits_d = acc_d[6:0];
          pend_cnt_d  = merge_total[2:0];
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = sh_out[7:0];
          out_last_d  = (emit_rem < TOT_W'(8));
          total_d     = emit_rem;
          if (emit_rem < TOT_W'(8)) begin
            pend_bits_d = acc_q[6:0] & ~(7'h7f << emit_rem[2:0]);
            pend_cnt_d  = emit_rem[2:0];
            state_d     = ST_IDLE;
          end
        end
      end

      ST_FLUSH_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = sh_out[7:0];
          out_last_d  = 1'b0;
          state_d     = ST_FLUSH_TRL;
        end
      end

      ST_FLUSH_TRL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = (pend_cnt_q == 3'd0) ? 8'd8 : {5'd0, pend_cnt_q};
          out_last_d  = 1'b1;
          pend_bits_d = '0;
          pend_cnt_d  = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    total_q    <= total_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

  // Pending bits above the pending count are always zero.
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_bits_q & (7'h7f << pend_cnt_q)) == 7'h00)
    else $error("pending bits hold stray data above the count");

  // A byte is only extracted while at least eight bits are held.
  a_emit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (total_q >= TOT_W'(8)))
    else $error("emit step entered with fewer than eight bits");

  // Straight after the merge the accumulator holds nothing above its bit count.
  // Later emit steps leave the bytes already sent in the upper bits.
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && $past(state_q) == ST_MERGE) |-> ((acc_q >> total_q) == '0))
    else $error("accumulator holds bits above its count");

  // The merge step only ever follows an accepted encode.
  a_merge_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> ($past(state_q) == ST_IDLE))
    else $error("merge step entered without an encode transfer");

  // A flush transfer always leads to a trailer byte sequence.
  a_flush_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cmd_i == pcbp_pkg::CMD_FLUSH) |=>
      (state_q == ST_FLUSH_DATA || state_q == ST_FLUSH_TRL))
    else $error("flush transfer did not start the flush sequence");

endmodule

`default_nettype wire
